// ===== rtl/plt_pkg.sv =====
// shared types and codes for the positional list table
// no dependencies
package plt_pkg;

    // slot and count fields in cell control, sized for the largest table
    localparam int SLOT_W = 11;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_CLEAR  = 2'd3
    } plt_mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_BEYOND  = 2'd2,
        STAT_MISSING = 2'd3
    } plt_status_t;

    typedef enum logic [1:0] {
        OP_HOLD    = 2'd0,
        OP_COMPARE = 2'd1,
        OP_INSERT  = 2'd2,
        OP_DELETE  = 2'd3
    } plt_op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CMP  = 2'd1,
        ST_EXEC = 2'd2
    } plt_state_t;

    typedef struct packed {
        plt_op_t            op;
        logic [31:0]        key;
        logic [SLOT_W-1:0]  anchor;
        logic [SLOT_W-1:0]  count;
    } plt_ctrl_t;

endpackage

// ===== rtl/positional_list_table_core.sv =====
// top level of the positional list table: control, cell row and result register
// depends on plt_pkg, plt_cell, plt_pick
//
//  channel  ports      payload
//  s_       tdata/user key, position; mode in tuser
//  m_       tdata      status, index, size
//
// every request passes a compare state across all cells, then an execute state
// with the priority pick and one shift of the cells from the anchor upward.
// a new request is taken in the execute cycle when the result register is free.
// aresetn empties the list; cell contents are not reset.
// a stalled result holds the block in execute until m_tready.
module positional_list_table_core
    import plt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key[31:0], position[38:32], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], index[7:2], size[14:8], zero pad
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    plt_state_t state_reg, state_next;
    plt_mode_t  mode_reg;
    logic [31:0] key_reg;
    logic [6:0]  pos_reg;
    logic [CW-1:0] count_reg, count_next;

    logic        out_valid_reg, out_valid_next;
    plt_status_t out_status_reg, out_status_next;
    logic [5:0]  out_index_reg, out_index_next;
    logic [6:0]  out_size_reg, out_size_next;

    plt_ctrl_t ctrl;
    logic [31:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic        found;
    logic [IW-1:0] pick_idx;
    logic [SLOT_W-1:0] pick_w, count_w, pos_w;
    logic        slot_free, accept, exec_go;

    assign pick_w  = SLOT_W'(pick_idx);
    assign count_w = SLOT_W'(count_reg);
    assign pos_w   = SLOT_W'(pos_reg);

    assign slot_free = !out_valid_reg || m_tready;
    assign exec_go   = (state_reg == ST_EXEC) && slot_free;
    assign s_tready  = (state_reg == ST_IDLE) || exec_go;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_size_next   = out_size_reg;
        ctrl.op         = OP_HOLD;
        ctrl.key        = key_reg;
        ctrl.anchor     = '0;
        ctrl.count      = count_w;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                ctrl.op    = OP_COMPARE;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_go) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_index_next  = '0;
                    unique case (mode_reg)
                        MODE_SEARCH: begin
                            if (found) begin
                                out_index_next = pick_w[5:0];
                            end else begin
                                out_status_next = STAT_MISSING;
                            end
                        end
                        MODE_INSERT: begin
                            if (count_reg >= CW'(CAPACITY)) begin
                                out_status_next = STAT_FULL;
                            end else if (pos_w > count_w) begin
                                out_status_next = STAT_BEYOND;
                            end else begin
                                ctrl.op        = OP_INSERT;
                                ctrl.anchor    = pos_w;
                                count_next     = count_reg + CW'(1);
                                out_index_next = pos_w[5:0];
                            end
                        end
                        MODE_DELETE: begin
                            if (found) begin
                                ctrl.op        = OP_DELETE;
                                ctrl.anchor    = pick_w;
                                count_next     = count_reg - CW'(1);
                                out_index_next = pick_w[5:0];
                            end else begin
                                out_status_next = STAT_MISSING;
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            out_status_next = STAT_OK;
                        end
                    endcase
                    out_size_next = 7'(SLOT_W'(count_next));
                    state_next    = accept ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= plt_mode_t'(s_tuser);
            key_reg  <= s_tdata[31:0];
            pos_reg  <= s_tdata[38:32];
        end
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_size_reg   <= out_size_next;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [31:0] left_d, right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = entry_w[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = entry_w[i+1];
        end
        plt_cell #(
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .entry      (entry_w[i]),
            .match      (match_vec[i])
        );
    end

    plt_pick #(
        .CAPACITY (CAPACITY)
    ) u_pick (
        .match_vec (match_vec),
        .found     (found),
        .pick_idx  (pick_idx)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_size_reg, out_index_reg, out_status_reg};

endmodule

// ===== rtl/plt_cell.sv =====
// one slot of the list: holds a key, compares it and shifts with its neighbours
// depends on plt_pkg
module plt_cell
    import plt_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic        aclk,
    input  plt_ctrl_t   ctrl,
    input  logic [31:0] left_data,
    input  logic [31:0] right_data,
    output logic [31:0] entry,
    output logic        match
);

    localparam logic [SLOT_W-1:0] SLOT      = SLOT_W'(IDX);
    localparam logic [SLOT_W-1:0] SLOT_NEXT = SLOT_W'(IDX + 1);

    logic [31:0] entry_reg, entry_next;
    logic        match_reg, match_next;

    always_comb begin
        entry_next = entry_reg;
        match_next = match_reg;
        case (ctrl.op)
            OP_COMPARE: begin
                match_next = (entry_reg == ctrl.key) && (SLOT < ctrl.count);
            end
            OP_INSERT: begin
                if (SLOT == ctrl.anchor) begin
                    entry_next = ctrl.key;
                end else if (SLOT > ctrl.anchor && SLOT <= ctrl.count) begin
                    entry_next = left_data;
                end
            end
            OP_DELETE: begin
                if (SLOT >= ctrl.anchor && SLOT_NEXT < ctrl.count) begin
                    entry_next = right_data;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// ===== rtl/plt_pick.sv =====
// lowest-position pick over the cell match flags
// depends on plt_pkg
module plt_pick
    import plt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic [CAPACITY-1:0]         match_vec,
    output logic                        found,
    output logic [$clog2(CAPACITY)-1:0] pick_idx
);

    localparam int IW = $clog2(CAPACITY);

    logic [CAPACITY-1:0] lowest;

    assign lowest = match_vec & (~match_vec + CAPACITY'(1));
    assign found  = |match_vec;

    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            pick_idx = pick_idx | ({IW{lowest[i]}} & IW'(i));
        end
    end

endmodule

// ===== dv/positional_list_table_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for positional_list_table_core: directed then random requests
// with idle and stall gaps on both channels, every result checked against a local list
// depends on plt_pkg and the rtl of positional_list_table_core
module positional_list_table_core_tb;
    import plt_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int RANDOM_REQUESTS = 1000;

    typedef struct {
        plt_mode_t   mode;
        logic [31:0] key;
        logic [6:0]  pos;
        int unsigned gap;
    } list_request_t;

    typedef struct {
        plt_status_t status;
        logic [5:0]  index;
        logic [6:0]  size;
    } list_outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // key[31:0], position[38:32], zero pad
    logic [1:0]  s_tuser = '0;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // status[1:0], index[7:2], size[14:8], zero pad

    list_request_t queued_requests[$];
    list_outcome_t list_outcomes[$];

    // list contents as the block should hold them
    logic [31:0] held_keys [LIST_DEPTH];
    int          held_count = 0;

    // list contents as seen while building the request stream
    logic [31:0] shadow_list[$];
    bit          calm_burst = 1'b0;

    int unsigned mismatches = 0;
    int unsigned requests_sent = 0;
    int unsigned results_checked = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};
    int unsigned peak_size = 0;
    int unsigned idle_count = 0;
    int unsigned stall_left = 0;

    positional_list_table_core #(.CAPACITY(LIST_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic list_outcome_t apply_to_list(plt_mode_t mode, logic [31:0] key,
                                                    logic [6:0] pos);
        list_outcome_t r;
        int            hit;
        r.status = STAT_OK;
        r.index  = '0;
        hit      = -1;
        if (mode == MODE_SEARCH || mode == MODE_DELETE) begin
            for (int i = 0; i < held_count; i++) begin
                if (hit < 0 && held_keys[i] == key) begin
                    hit = i;
                end
            end
        end
        case (mode)
            MODE_SEARCH: begin
                if (hit < 0) r.status = STAT_MISSING;
                else r.index = hit[5:0];
            end
            MODE_INSERT: begin
                if (held_count >= LIST_DEPTH) begin
                    r.status = STAT_FULL;
                end else if (int'(pos) > held_count) begin
                    r.status = STAT_BEYOND;
                end else begin
                    for (int i = held_count; i > int'(pos); i--) begin
                        held_keys[i] = held_keys[i-1];
                    end
                    held_keys[pos] = key;
                    held_count++;
                    r.index = pos[5:0];
                end
            end
            MODE_DELETE: begin
                if (hit < 0) begin
                    r.status = STAT_MISSING;
                end else begin
                    for (int i = hit; i + 1 < held_count; i++) begin
                        held_keys[i] = held_keys[i+1];
                    end
                    held_count--;
                    r.index = hit[5:0];
                end
            end
            default: begin
                held_count = 0;
            end
        endcase
        r.size = held_count[6:0];
        return r;
    endfunction

    function automatic int shadow_find(logic [31:0] key);
        for (int i = 0; i < shadow_list.size(); i++) begin
            if (shadow_list[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic void queue_request(plt_mode_t mode, logic [31:0] key, logic [6:0] pos);
        list_request_t req;
        int            hit;
        req.mode = mode;
        req.key  = key;
        req.pos  = pos;
        req.gap  = calm_burst ? 0 : $urandom_range(0, 13);
        queued_requests.push_back(req);
        case (mode)
            MODE_INSERT: begin
                if (shadow_list.size() < LIST_DEPTH && int'(pos) <= shadow_list.size())
                    shadow_list.insert(int'(pos), key);
            end
            MODE_DELETE: begin
                hit = shadow_find(key);
                if (hit >= 0) shadow_list.delete(hit);
            end
            MODE_CLEAR: begin
                shadow_list.delete();
            end
            default: begin
            end
        endcase
    endfunction

    // held keys, a small pool with repeats and extremes, or anything at all
    function automatic logic [31:0] pick_key();
        logic [31:0] pool [8];
        int unsigned r;
        pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0007};
        r = $urandom_range(0, 99);
        if (r < 40 && shadow_list.size() > 0)
            return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        if (r < 70)
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [6:0] pick_position();
        int unsigned n;
        int unsigned r;
        n = shadow_list.size();
        r = $urandom_range(0, 9);
        if (r == 0) return 7'd0;
        if (r == 1) return n[6:0];
        if (r == 2) return 7'($urandom_range(n + 1, 127));
        return 7'($urandom_range(0, n));
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            idle_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                list_outcomes.push_back(apply_to_list(plt_mode_t'(s_tuser), s_tdata[31:0],
                                                      s_tdata[38:32]));
                requests_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (queued_requests.size() > 0 && idle_count >= queued_requests[0].gap) begin
                    s_tdata    <= {1'b0, queued_requests[0].pos, queued_requests[0].key};
                    s_tuser    <= queued_requests[0].mode;
                    s_tvalid   <= 1'b1;
                    idle_count = 0;
                    void'(queued_requests.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                    if (queued_requests.size() > 0) idle_count++;
                end
            end
        end
    end

    // result monitor and back-pressure
    always @(posedge aclk) begin
        list_outcome_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (list_outcomes.size() == 0) begin
                    flag_mismatch("result with no request waiting", 32'(m_tdata), '0);
                end else begin
                    want = list_outcomes.pop_front();
                    if (m_tdata[1:0] != want.status)
                        flag_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
                    if (m_tdata[7:2] != want.index)
                        flag_mismatch("index", 32'(m_tdata[7:2]), 32'(want.index));
                    if (m_tdata[14:8] != want.size)
                        flag_mismatch("size", 32'(m_tdata[14:8]), 32'(want.size));
                    status_seen[want.status]++;
                    if (want.size > peak_size) peak_size = 32'(want.size);
                end
                results_checked++;
                stall_left = ((results_checked / 48) % 3 == 0) ? 0 : $urandom_range(0, 13);
                m_tready <= (stall_left == 0);
            end else if (!m_tready) begin
                if (stall_left <= 1) m_tready <= 1'b1;
                if (stall_left > 0) stall_left--;
            end
        end
    end

    initial begin
        int unsigned   random_total;
        int unsigned   burst_kind;
        int unsigned   burst_len;
        int unsigned   r;
        plt_mode_t     mode;
        logic [31:0]   key;

        // empty list, edge positions, duplicates, head and tail deletes, stale bits
        queue_request(MODE_SEARCH, 32'h0000_0000, 7'd0);
        queue_request(MODE_DELETE, 32'h0000_0005, 7'd127);
        queue_request(MODE_INSERT, 32'h1111_1111, 7'd1);
        queue_request(MODE_INSERT, 32'h2222_2222, 7'd127);
        queue_request(MODE_INSERT, 32'h8000_0000, 7'd0);
        queue_request(MODE_INSERT, 32'h7FFF_FFFF, 7'd1);
        queue_request(MODE_INSERT, 32'hFFFF_FFFF, 7'd0);
        queue_request(MODE_INSERT, 32'h0000_0000, 7'd1);
        queue_request(MODE_INSERT, 32'h7FFF_FFFF, 7'd4);
        queue_request(MODE_SEARCH, 32'h7FFF_FFFF, 7'd64);
        queue_request(MODE_SEARCH, 32'h1234_5678, 7'd0);
        queue_request(MODE_DELETE, 32'h7FFF_FFFF, 7'd0);
        queue_request(MODE_SEARCH, 32'h7FFF_FFFF, 7'd0);
        queue_request(MODE_DELETE, 32'hFFFF_FFFF, 7'd0);
        queue_request(MODE_DELETE, 32'h7FFF_FFFF, 7'd0);
        queue_request(MODE_DELETE, 32'h0000_0001, 7'd0);
        queue_request(MODE_CLEAR, 32'hFFFF_FFFF, 7'd127);
        queue_request(MODE_SEARCH, 32'h0000_0000, 7'd0);
        queue_request(MODE_INSERT, 32'h0000_0000, 7'd0);
        queue_request(MODE_SEARCH, 32'h0000_0000, 7'd0);

        // bursts that grow, shrink or mix the list, with the odd clear
        random_total = 0;
        while (random_total < RANDOM_REQUESTS) begin
            burst_kind = $urandom_range(0, 9);
            burst_len  = (burst_kind == 9) ? 1 : $urandom_range(20, 100);
            calm_burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < burst_len; n++) begin
                r = $urandom_range(0, 99);
                if (burst_kind == 9)
                    mode = MODE_CLEAR;
                else if (burst_kind <= 3)
                    mode = (r < 75) ? MODE_INSERT : (r < 90) ? MODE_SEARCH : MODE_DELETE;
                else if (burst_kind <= 5)
                    mode = (r < 70) ? MODE_DELETE : (r < 90) ? MODE_SEARCH : MODE_INSERT;
                else
                    mode = (r < 32) ? MODE_SEARCH : (r < 64) ? MODE_INSERT :
                           (r < 97) ? MODE_DELETE : MODE_CLEAR;
                key = pick_key();
                if (mode == MODE_INSERT) begin
                    queue_request(mode, key, pick_position());
                end else begin
                    queue_request(mode, key, 7'($urandom_range(0, 127)));
                end
                random_total++;
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (queued_requests.size() > 0 || s_tvalid || list_outcomes.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d requests sent, %0d results checked, largest list %0d entries",
                 requests_sent, results_checked, peak_size);
        $display("outcomes: ok %0d, full %0d, beyond count %0d, key missing %0d",
                 status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_BEYOND],
                 status_seen[STAT_MISSING]);
        if (mismatches == 0 && list_outcomes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timed out with %0d results outstanding", list_outcomes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
